>>> rtl/rpst_pkg.sv
// rpst_pkg: types and constants shared by the rank-packed sparse slot table.
// No dependencies.
package rpst_pkg;

   localparam int POS_W   = 5;
   localparam int TAG_W   = 2;
   localparam int MODE_W  = 2;
   localparam int COUNT_W = 5;
   localparam int WORD_W  = 32;

   localparam logic [MODE_W-1:0] MODE_GET    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SET    = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic [POS_W-1:0]  position;
      logic [TAG_W-1:0]  tag_in;
   } req_type;

   typedef struct packed {
      logic               was_occupied;
      logic [TAG_W-1:0]   tag_out;
      logic [COUNT_W-1:0] stored_count;
      logic               rejected;
      logic [WORD_W-1:0]  occupancy_map;
      logic [WORD_W-1:0]  packed_tags;
   } rsp_type;

   // One stored tag and the position it belongs to.
   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] pos;
      logic [TAG_W-1:0] tag;
   } entry_type;

   // Update broadcast to every cell of the chain.
   typedef struct packed {
      logic             ins;
      logic             rem;
      logic             ovr;
      logic [POS_W-1:0] pos;
      logic [TAG_W-1:0] tag;
   } cmd_type;

endpackage

>>> rtl/rank_packed_sparse_slot_table_core.sv
// rank_packed_sparse_slot_table_core: sparse position-to-tag table, tags packed by rank.
// Built from a chain of rpst_cell slots. Depends on rpst_pkg and rpst_cell.
//
// Usage:
//   A request (req_data: mode, position, tag_in) is taken at a rising edge where
//   start is high and busy is low. Mode get reads a position, set writes a tag
//   (insert with the higher ranks moving up, or overwrite in place), remove
//   deletes a tag and moves the higher ranks down.
//   Each request gives one response on rsp_data, marked by rsp_valid for one
//   cycle, in the cycle right after the request was taken. The receiver has no
//   way to stall it and must take it in that cycle.
//   Latency is one cycle and a new request may be taken every cycle: the
//   slot chain does the shift of all ranks in the cycle of the request, each
//   cell looking only at its two neighbors and the broadcast position.
//   Set on a new position with MAX_STORED tags held is refused (rejected).
//   Positions at or above NUM_POSITIONS read as empty and are never written.
//   Reset empties the table; busy is high during reset and the cycle after.
module rank_packed_sparse_slot_table_core
   import rpst_pkg::*;
#(
   parameter int NUM_POSITIONS = 32,
   parameter int MAX_STORED    = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  req_type req_data,
   output logic    busy,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   entry_type cur   [MAX_STORED];
   entry_type nxt   [MAX_STORED];
   entry_type below [MAX_STORED];
   entry_type above [MAX_STORED];

   logic               busy_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_in;
   logic [WORD_W-1:0]  occ_ff;
   logic [WORD_W-1:0]  occ_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;
   logic               accept;
   logic               in_range;
   logic               was;
   logic [TAG_W-1:0]   old_tag;
   logic               is_set;
   logic               full;
   logic               rej;
   cmd_type            cmd;
   logic [WORD_W-1:0]  packed_next;

   assign accept   = start && !busy_ff;
   assign in_range = {1'b0, req_data.position} < (POS_W+1)'(NUM_POSITIONS);
   assign is_set   = req_data.mode == MODE_SET;
   assign full     = count_ff >= COUNT_W'(MAX_STORED);

   always_comb begin
      was     = 1'b0;
      old_tag = '0;
      for (int k = 0; k < MAX_STORED; k++) begin
         if (cur[k].valid && (cur[k].pos == req_data.position)) begin
            was     = 1'b1;
            old_tag = old_tag | cur[k].tag;
         end
      end
      was     = was && in_range;
      old_tag = was ? old_tag : '0;
   end

   always_comb begin
      rej     = accept && in_range && is_set && !was && full;
      cmd.ins = accept && in_range && is_set && !was && !full;
      cmd.ovr = accept && is_set && was;
      cmd.rem = accept && (req_data.mode == MODE_REMOVE) && was;
      cmd.pos = req_data.position;
      cmd.tag = req_data.tag_in;
   end

   always_comb begin
      for (int k = 0; k < MAX_STORED; k++) begin
         if (k == 0) begin
            below[k] = '{valid: 1'b1, pos: '0, tag: '0};
         end else begin
            below[k] = cur[k-1];
         end
         if (k == MAX_STORED - 1) begin
            above[k] = '0;
         end else begin
            above[k] = cur[k+1];
         end
      end
   end

   for (genvar g = 0; g < MAX_STORED; g++) begin : g_slot
      rpst_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cmd        (cmd),
         .below      (below[g]),
         .above      (above[g]),
         .entry      (cur[g]),
         .entry_next (nxt[g])
      );
   end

   always_comb begin
      packed_next = '0;
      for (int k = 0; k < MAX_STORED; k++) begin
         packed_next[2*k +: TAG_W] = nxt[k].valid ? nxt[k].tag : '0;
      end
   end

   always_comb begin
      occ_in   = occ_ff;
      count_in = count_ff;
      if (cmd.ins) begin
         occ_in[req_data.position] = 1'b1;
         count_in = count_ff + COUNT_W'(1);
      end else if (cmd.rem) begin
         occ_in[req_data.position] = 1'b0;
         count_in = count_ff - COUNT_W'(1);
      end
      rsp_in.was_occupied  = was;
      rsp_in.tag_out       = old_tag;
      rsp_in.stored_count  = count_in;
      rsp_in.rejected      = rej;
      rsp_in.occupancy_map = occ_in;
      rsp_in.packed_tags   = packed_next;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
         occ_ff       <= '0;
         count_ff     <= '0;
      end else begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= accept;
         occ_ff       <= occ_in;
         count_ff     <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

>>> rtl/rpst_cell.sv
// rpst_cell: one rank slot of the table, kept sorted by position.
// Takes from its lower neighbor on insert, from its upper neighbor on remove.
// Depends on rpst_pkg.
module rpst_cell
   import rpst_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  cmd_type   cmd,
   input  entry_type below,
   input  entry_type above,
   output entry_type entry,
   output entry_type entry_next
);

   entry_type entry_ff;
   entry_type entry_in;
   entry_type new_entry;
   logic      self_gt;
   logic      self_ge;
   logic      below_gt;

   always_comb begin
      new_entry.valid = 1'b1;
      new_entry.pos   = cmd.pos;
      new_entry.tag   = cmd.tag;
      self_gt  = entry_ff.valid && (entry_ff.pos > cmd.pos);
      self_ge  = entry_ff.valid && (entry_ff.pos >= cmd.pos);
      below_gt = below.valid && (below.pos > cmd.pos);
      entry_in = entry_ff;
      if (cmd.ins) begin
         if (!entry_ff.valid || self_gt) begin
            if (below_gt) begin
               entry_in = below;
            end else if (below.valid) begin
               entry_in = new_entry;
            end
         end
      end else if (cmd.rem) begin
         if (self_ge) begin
            entry_in = above;
         end
      end else if (cmd.ovr) begin
         if (entry_ff.valid && (entry_ff.pos == cmd.pos)) begin
            entry_in.tag = cmd.tag;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule
